// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file vna_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define VNA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define VNA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/vna_pkg.sv =====
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMD_W = 2;
  localparam int POS_W = 16;
  localparam int EDGE_W = POS_W + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int CR_W = PROD_W + 1;
  localparam int SUM_W = 24;
  localparam int UNIT_W = 16;
  localparam int VTX_W = 3 * POS_W;
  localparam int NRM_W = 3 * SUM_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  typedef logic [2:0][CR_W-1:0] cross_vec_t;
  typedef logic [2:0][UNIT_W-1:0] unit_vec_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

// ===== hw/rtl/vna_if.sv =====
interface vna_req_if;
  import vna_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [IDX_W-1:0] index_c;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  modport source(output valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                 input ready);
  modport sink(input valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
               output ready);
endinterface

interface vna_rsp_if;
  import vna_pkg::*;
  logic valid;
  logic ready;
  logic status;
  logic signed [SUM_W-1:0] normal_x;
  logic signed [SUM_W-1:0] normal_y;
  logic signed [SUM_W-1:0] normal_z;
  logic saturated;
  modport source(output valid, status, normal_x, normal_y, normal_z, saturated,
                 input ready);
  modport sink(input valid, status, normal_x, normal_y, normal_z, saturated,
               output ready);
endinterface

interface vna_cfg_if;
  import vna_pkg::*;
  logic valid;
  logic ready;
  logic [CNT_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/vna_ram.sv =====
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/vna_norm.sv =====
module vna_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vna_pkg::cross_vec_t cr,
  output vna_pkg::unit_vec_t  unit,
  output vna_pkg::norm_stat_t stat
);
  import vna_pkg::*;

  localparam int MAG_W = 30;
  localparam int SQ_W = 2 * MAG_W;
  localparam int RT_W = 64;
  localparam int NUM_W = MAG_W + 15;
  localparam int Q_W = 15;
  localparam int REM_W = 32;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MAG = 3'd1;
  localparam logic [2:0] U_SHR = 3'd2;
  localparam logic [2:0] U_SHL = 3'd3;
  localparam logic [2:0] U_SQ = 3'd4;
  localparam logic [2:0] U_SQRT = 3'd5;
  localparam logic [2:0] U_DLOAD = 3'd6;
  localparam logic [2:0] U_DIV = 3'd7;

  logic [2:0] state;
  logic [CR_W-1:0] mag [3];
  logic [2:0] neg;
  logic [5:0] cnt;
  logic [1:0] comp;
  logic [SQ_W-1:0] sq_prod;
  logic [RT_W-1:0] len;
  logic [RT_W-1:0] root;
  logic [RT_W-1:0] bit_q;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0] low;
  logic [Q_W-1:0] quo;
  logic done;
  logic zero;

  logic [MAG_W-1:0] sq_op;
  logic [MAG_W-1:0] div_mag;
  logic [RT_W-1:0] rt_sum;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] trial;
  logic [Q_W-1:0] quo_next;
  logic [REM_W-1:0] rem_next;
  logic all_zero;
  logic any_high;
  logic any_top;

  always_comb begin
    case (cnt[1:0])
      2'd0: sq_op = mag[0][MAG_W-1:0];
      2'd1: sq_op = mag[1][MAG_W-1:0];
      2'd2: sq_op = mag[2][MAG_W-1:0];
      default: sq_op = '0;
    endcase
    case (comp)
      2'd0: div_mag = mag[0][MAG_W-1:0];
      2'd1: div_mag = mag[1][MAG_W-1:0];
      default: div_mag = mag[2][MAG_W-1:0];
    endcase
    all_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
    any_high = (mag[0][CR_W-1:MAG_W] != '0) || (mag[1][CR_W-1:MAG_W] != '0) ||
               (mag[2][CR_W-1:MAG_W] != '0);
    any_top = mag[0][MAG_W-1] || mag[1][MAG_W-1] || mag[2][MAG_W-1];
    rt_sum = root + bit_q;
    num = {div_mag, 14'd0} + NUM_W'(root[RT_W-1:1]);
    trial = {rem[REM_W-2:0], low[Q_W-1]};
    if (trial >= root[REM_W-1:0]) begin
      rem_next = trial - root[REM_W-1:0];
      quo_next = {quo[Q_W-2:0], 1'b1};
    end else begin
      rem_next = trial;
      quo_next = {quo[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done <= 1'b0;
      zero <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (start) begin
            state <= U_MAG;
          end
        end
        U_MAG: begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= cr[k][CR_W-1];
            mag[k] <= cr[k][CR_W-1] ? (~cr[k] + 1'b1) : cr[k];
          end
          state <= U_SHR;
        end
        U_SHR: begin
          if (all_zero) begin
            zero <= 1'b1;
            done <= 1'b1;
            state <= U_IDLE;
          end else if (any_high) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else begin
            state <= U_SHL;
          end
        end
        U_SHL: begin
          if (!any_top) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            cnt <= '0;
            len <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          sq_prod <= sq_op * sq_op;
          if (cnt != '0) begin
            len <= len + RT_W'(sq_prod);
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd3) begin
            cnt <= '0;
            root <= '0;
            bit_q <= RT_W'(1) << 62;
            state <= U_SQRT;
          end
        end
        U_SQRT: begin
          if (len >= rt_sum) begin
            len <= len - rt_sum;
            root <= (root >> 1) + bit_q;
          end else begin
            root <= root >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 6'd31) begin
            comp <= '0;
            state <= U_DLOAD;
          end
        end
        U_DLOAD: begin
          rem <= REM_W'(num[NUM_W-1:Q_W]);
          low <= num[Q_W-1:0];
          quo <= '0;
          cnt <= '0;
          state <= U_DIV;
        end
        U_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          low <= low << 1;
          cnt <= cnt + 1'b1;
          if (cnt == 6'(Q_W - 1)) begin
            unit[comp] <= neg[comp] ? (~UNIT_W'(quo_next) + 1'b1) : UNIT_W'(quo_next);
            if (comp == 2'd2) begin
              zero <= 1'b0;
              done <= 1'b1;
              state <= U_IDLE;
            end else begin
              comp <= comp + 1'b1;
              state <= U_DLOAD;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.zero = zero;

endmodule

// ===== hw/rtl/vertex_normal_accumulator_unit.sv =====
// Per-vertex normal accumulator for a triangle mesh.
// The req channel carries one command per transfer: load a vertex position
// (which clears its normal sum), add a triangle, or read a normal sum. The rsp
// channel returns exactly one result per command, in order. The cfg channel
// writes vertex_count; it is always ready, and the user must write it only
// while idle; the block itself does not enforce this. One command is worked
// on at a time. A load goes from the exec state to the result register, and a
// read also passes a read-data state. A triangle add waits on the normalize
// unit: a one-bit-per-cycle shift search of up to 29 steps, a 32-step square
// root and three divisions, followed by three read-modify-write passes on
// the single-port normal memory. A triangle with a zero-length cross
// product skips those passes. After reset the block sweeps the normal memory
// to zero, one entry a cycle; req.ready stays low during that sweep.
// The result sits in an output register. A new command is taken while it
// waits, but the next result holds until the receiver takes the previous one.
module vertex_normal_accumulator_unit (
  input logic      clk,
  input logic      rst,
  vna_req_if.sink  req,
  vna_rsp_if.source rsp,
  vna_cfg_if.sink  cfg
);
  import vna_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_RD_DATA = 4'd3;
  localparam logic [3:0] S_V0 = 4'd4;
  localparam logic [3:0] S_V1 = 4'd5;
  localparam logic [3:0] S_V2 = 4'd6;
  localparam logic [3:0] S_EDGE = 4'd7;
  localparam logic [3:0] S_MUL = 4'd8;
  localparam logic [3:0] S_ACC = 4'd9;
  localparam logic [3:0] S_NORM = 4'd10;
  localparam logic [3:0] S_SRD = 4'd11;
  localparam logic [3:0] S_SWR = 4'd12;
  localparam logic [3:0] S_RESP = 4'd13;

  logic [3:0] state;
  logic [IDX_W-1:0] clr_addr;
  logic [CNT_W-1:0] vertex_count;
  logic [CMD_W-1:0] cmd_q;
  logic [IDX_W-1:0] ia;
  logic [IDX_W-1:0] ib;
  logic [IDX_W-1:0] ic;
  logic [VTX_W-1:0] pos_q;
  logic [VTX_W-1:0] pa;
  logic [VTX_W-1:0] pb;
  logic [VTX_W-1:0] pc;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] prod;
  cross_vec_t cr;
  logic [2:0] mstep;
  logic [1:0] corner;
  logic norm_start;
  logic status_q;
  logic [NRM_W-1:0] rd_q;
  logic res_valid;
  logic res_status;
  logic [NRM_W-1:0] res_data;

  logic vtx_we;
  logic [IDX_W-1:0] vtx_addr;
  logic [VTX_W-1:0] vtx_rdata;
  logic nrm_we;
  logic [IDX_W-1:0] nrm_addr;
  logic [NRM_W-1:0] nrm_wdata;
  logic [NRM_W-1:0] nrm_rdata;
  logic [IDX_W-1:0] corner_idx;
  logic signed [EDGE_W-1:0] mul_a;
  logic signed [EDGE_W-1:0] mul_b;
  logic signed [SUM_W:0] s_ext [3];
  logic [NRM_W-1:0] sum_new;
  unit_vec_t unit;
  norm_stat_t norm_stat;

  function automatic logic idx_ok(logic [IDX_W-1:0] i);
    return {1'b0, i} < vertex_count;
  endfunction

  vna_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
    .clk(clk), .we(vtx_we), .addr(vtx_addr), .wdata(pos_q), .rdata(vtx_rdata)
  );

  vna_ram #(.WIDTH(NRM_W), .DEPTH(MAX_VERTICES)) u_nrm_ram (
    .clk(clk), .we(nrm_we), .addr(nrm_addr), .wdata(nrm_wdata), .rdata(nrm_rdata)
  );

  vna_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start), .cr(cr), .unit(unit), .stat(norm_stat)
  );

  always_comb begin
    case (corner)
      2'd0: corner_idx = ia;
      2'd1: corner_idx = ib;
      default: corner_idx = ic;
    endcase
    case (mstep)
      3'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
      3'd5: begin mul_a = e1[1]; mul_b = e2[0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    sum_new = '0;
    sum_new[NRM_W-1] = nrm_rdata[NRM_W-1];
    for (int k = 0; k < 3; k++) begin
      s_ext[k] = (SUM_W + 1)'($signed(nrm_rdata[k*SUM_W +: SUM_W])) +
                 (SUM_W + 1)'($signed(unit[k]));
      if (s_ext[k][SUM_W] != s_ext[k][SUM_W-1]) begin
        sum_new[k*SUM_W +: SUM_W] = s_ext[k][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                    : {1'b0, {(SUM_W-1){1'b1}}};
        sum_new[NRM_W-1] = 1'b1;
      end else begin
        sum_new[k*SUM_W +: SUM_W] = s_ext[k][SUM_W-1:0];
      end
    end
  end

  always_comb begin
    vtx_we = 1'b0;
    vtx_addr = ia;
    nrm_we = 1'b0;
    nrm_addr = ia;
    nrm_wdata = '0;
    case (state)
      S_CLEAR: begin
        nrm_we = 1'b1;
        nrm_addr = clr_addr;
      end
      S_EXEC: begin
        if (cmd_q == CMD_LOAD && idx_ok(ia)) begin
          vtx_we = 1'b1;
          nrm_we = 1'b1;
        end
      end
      S_V0: vtx_addr = ib;
      S_V1: vtx_addr = ic;
      S_SRD: nrm_addr = corner_idx;
      S_SWR: begin
        nrm_we = 1'b1;
        nrm_addr = corner_idx;
        nrm_wdata = sum_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      vertex_count <= '0;
      res_valid <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      norm_start <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        vertex_count <= cfg.data;
      end
      if (res_valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(MAX_VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.cmd;
            ia <= req.index_a;
            ib <= req.index_b;
            ic <= req.index_c;
            pos_q <= {req.pos_z, req.pos_y, req.pos_x};
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q <= 1'b0;
          rd_q <= '0;
          state <= S_RESP;
          case (cmd_q)
            CMD_LOAD: status_q <= !idx_ok(ia);
            CMD_READ: begin
              if (idx_ok(ia)) state <= S_RD_DATA;
              else status_q <= 1'b1;
            end
            CMD_ADD: begin
              if (idx_ok(ia) && idx_ok(ib) && idx_ok(ic)) state <= S_V0;
              else status_q <= 1'b1;
            end
            default: ;
          endcase
        end
        S_RD_DATA: begin
          rd_q <= nrm_rdata;
          state <= S_RESP;
        end
        S_V0: begin
          pa <= vtx_rdata;
          state <= S_V1;
        end
        S_V1: begin
          pb <= vtx_rdata;
          state <= S_V2;
        end
        S_V2: begin
          pc <= vtx_rdata;
          state <= S_EDGE;
        end
        S_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            e1[k] <= EDGE_W'($signed(pb[k*POS_W +: POS_W])) -
                     EDGE_W'($signed(pa[k*POS_W +: POS_W]));
            e2[k] <= EDGE_W'($signed(pc[k*POS_W +: POS_W])) -
                     EDGE_W'($signed(pa[k*POS_W +: POS_W]));
          end
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!mstep[0]) cr[mstep[2:1]] <= CR_W'(prod);
          else cr[mstep[2:1]] <= cr[mstep[2:1]] - CR_W'(prod);
          mstep <= mstep + 1'b1;
          if (mstep == 3'd5) begin
            norm_start <= 1'b1;
            state <= S_NORM;
          end else begin
            state <= S_MUL;
          end
        end
        S_NORM: begin
          if (norm_stat.done) begin
            corner <= '0;
            state <= norm_stat.zero ? S_RESP : S_SRD;
          end
        end
        S_SRD: state <= S_SWR;
        S_SWR: begin
          corner <= corner + 1'b1;
          state <= (corner == 2'd2) ? S_RESP : S_SRD;
        end
        S_RESP: begin
          if (!res_valid || rsp.ready) begin
            res_valid <= 1'b1;
            res_status <= status_q;
            res_data <= rd_q;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = res_valid;
  assign rsp.status = res_status;
  assign rsp.normal_x = res_data[0 +: SUM_W];
  assign rsp.normal_y = res_data[SUM_W +: SUM_W];
  assign rsp.normal_z = res_data[2*SUM_W +: SUM_W];
  assign rsp.saturated = res_data[NRM_W-1];

endmodule

// ===== hw/rtl/vna_checker.sv =====
`include "assert_macros.svh"

module vna_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_status,
  input logic [vna_pkg::SUM_W-1:0]  rsp_normal_x,
  input logic [vna_pkg::SUM_W-1:0]  rsp_normal_y,
  input logic [vna_pkg::SUM_W-1:0]  rsp_normal_z,
  input logic                       rsp_saturated
);
  import vna_pkg::*;

  // Reset leaves no result pending.
  `VNA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp_valid, "result valid after reset")

  // A stalled result holds its payload.
  `VNA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_saturated}), "stalled result changed")

  // A rejected command returns no normal data.
  `VNA_ASSERT(a_err_clean, clk, rst, rsp_valid && rsp_status |-> rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 && !rsp_saturated, "error result has data")

  // Commands are taken one at a time.
  `VNA_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "back to back transfer accepted")

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.status),
  .rsp_normal_x(rsp.normal_x),
  .rsp_normal_y(rsp.normal_y),
  .rsp_normal_z(rsp.normal_z),
  .rsp_saturated(rsp.saturated)
);
